// ===== rtl/core/dsit_pkg.sv =====
package dsit_pkg;

    localparam int TABLE_DEPTH   = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_W         = 5;
    localparam int CMP_W         = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
    localparam int KEY_W         = 21;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [11:0] key_year;
        logic [3:0]  key_month;
        logic [4:0]  key_day;
        logic [31:0] record_payload;
        logic [3:0]  read_index;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  insert_position;
        logic [4:0]  entry_count;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [31:0] out_payload;
    } t_out_word;

    typedef struct packed {
        logic [11:0]              year;
        logic [3:0]               month;
        logic [4:0]               day;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic shift_en;
        logic occupied;
        logic prev_keep;
    } t_cell_ctl;

    function automatic logic [KEY_W-1:0] date_key(input t_entry e);
        return {e.year, e.month, e.day};
    endfunction

endpackage

// ===== rtl/core/dsit_cell.sv =====
module dsit_cell (
    input  logic               i_clk,
    input  dsit_pkg::t_cell_ctl i_ctl,
    input  dsit_pkg::t_entry    i_new,
    input  dsit_pkg::t_entry    i_prev,
    output dsit_pkg::t_entry    o_entry,
    output logic                o_keep
);

    dsit_pkg::t_entry r_entry;
    dsit_pkg::t_entry n_entry;

    // An occupied cell whose date is the same or later keeps its entry.
    assign o_keep = i_ctl.occupied &&
                    (dsit_pkg::date_key(r_entry) >= dsit_pkg::date_key(i_new));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_en && !o_keep) begin
            n_entry = i_ctl.prev_keep ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/date_sorted_insert_table_core.sv =====
// Sorted date table, newest first, built as a row of cells.
// Input channel: i_in_valid / o_in_ready with word i_in_word. An insert word
// places its record after every stored entry with the same or a later date;
// a read word returns the entry at read_index.
// Output channel: o_out_valid / i_out_ready with word o_out_word, one result
// word for every input word, in order.
// The result word sits in the output register on the cycle after the input
// word is taken. Throughput is one word per cycle while the receiver keeps
// taking result words, because every cell compares its date with the new
// key in parallel and the whole row shifts in that same cycle.
// When the receiver stalls, the output register holds its word and
// o_in_ready stays low until that word is taken.
// Configuration: i_cfg_we writes i_cfg_wdata into the capacity register.
// Reset clears the entry count and sets the capacity to 16; the cell
// contents are not cleared, and no read can reach an entry beyond the count.
module date_sorted_insert_table_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dsit_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dsit_pkg::t_out_word o_out_word
);

    localparam int DEPTH = dsit_pkg::TABLE_DEPTH;

    logic [dsit_pkg::CAP_W-1:0]   r_capacity;
    logic [dsit_pkg::COUNT_W-1:0] r_count;
    logic [dsit_pkg::COUNT_W-1:0] n_count;
    logic                         r_out_valid;
    dsit_pkg::t_out_word          r_out;
    dsit_pkg::t_out_word          n_out;

    logic                         w_take;
    logic                         w_room;
    logic                         w_do_insert;
    logic                         w_rd_ok;
    dsit_pkg::t_entry             w_new;
    dsit_pkg::t_entry             w_entry [DEPTH];
    dsit_pkg::t_entry             w_rd_entry;
    logic [DEPTH-1:0]             w_keep;
    logic [DEPTH-1:0]             w_ins;
    logic [dsit_pkg::IDX_W-1:0]   w_pos;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;

    assign w_new.year    = i_in_word.key_year;
    assign w_new.month   = i_in_word.key_month;
    assign w_new.day     = i_in_word.key_day;
    assign w_new.payload = i_in_word.record_payload[dsit_pkg::PAYLOAD_WIDTH-1:0];

    assign w_room = (r_count < dsit_pkg::COUNT_W'(DEPTH)) &&
                    (dsit_pkg::CMP_W'(r_count) < dsit_pkg::CMP_W'(r_capacity));
    assign w_do_insert = w_take && (i_in_word.opcode == dsit_pkg::OP_INSERT) && w_room;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dsit_pkg::t_cell_ctl w_ctl;
        dsit_pkg::t_entry    w_prev;

        assign w_ctl.shift_en  = w_do_insert;
        assign w_ctl.occupied  = dsit_pkg::COUNT_W'(g) < r_count;
        if (g == 0) begin : g_head
            assign w_ctl.prev_keep = 1'b1;
            assign w_prev          = w_new;
        end else begin : g_body
            assign w_ctl.prev_keep = w_keep[g-1];
            assign w_prev          = w_entry[g-1];
        end
        assign w_ins[g] = w_ctl.prev_keep && !w_keep[g];

        dsit_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_prev  (w_prev),
            .o_entry (w_entry[g]),
            .o_keep  (w_keep[g])
        );
    end

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_ins[i]) begin
                w_pos = w_pos | dsit_pkg::IDX_W'(i);
            end
        end
    end

    assign w_rd_ok    = dsit_pkg::COUNT_W'(i_in_word.read_index) < r_count;
    assign w_rd_entry = w_entry[dsit_pkg::IDX_W'(i_in_word.read_index)];

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        if (i_in_word.opcode == dsit_pkg::OP_INSERT) begin
            if (w_room) begin
                n_count               = r_count + 1'b1;
                n_out.accepted        = 1'b1;
                n_out.insert_position = 4'(w_pos);
            end
        end else if (w_rd_ok) begin
            n_out.accepted    = 1'b1;
            n_out.out_year    = w_rd_entry.year;
            n_out.out_month   = w_rd_entry.month;
            n_out.out_day     = w_rd_entry.day;
            n_out.out_payload = 32'(w_rd_entry.payload);
        end
        n_out.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= dsit_pkg::CAP_W'(16);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dsit_pkg::COUNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_insert |-> $onehot(w_ins))
        else $error("insert does not find exactly one slot");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_insert |=> r_count == $past(r_count) + 1'b1)
        else $error("count did not grow after an insert");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in_word.opcode == dsit_pkg::OP_INSERT && w_room) |=>
        (5'(o_out_word.insert_position) < o_out_word.entry_count))
        else $error("insert position beyond entry count");

    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_do_insert) |=> r_count == $past(r_count))
        else $error("count changed without an insert");

endmodule

// ===== verif/date_table_checker.sv =====
module date_table_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  dsit_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  dsit_pkg::t_out_word i_out_word,
    output int                  o_mismatches,
    output int                  o_due
);

    dsit_pkg::t_entry             table_rows [dsit_pkg::TABLE_DEPTH];
    logic [dsit_pkg::COUNT_W-1:0] row_count;
    logic [dsit_pkg::CAP_W-1:0]   capacity;
    dsit_pkg::t_out_word          due_results [$];
    int                           mismatch_total = 0;
    int                           due_total = 0;

    assign o_mismatches = mismatch_total;
    assign o_due        = due_total;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
        end
    endtask

    task automatic place_or_fetch(input dsit_pkg::t_in_word w,
                                  output dsit_pkg::t_out_word r);
        logic [4:0]  limit;
        logic [4:0]  slot;
        logic [4:0]  k;
        logic [20:0] new_key;
        r = '0;
        limit = (capacity < 5'(dsit_pkg::TABLE_DEPTH)) ?
                capacity : 5'(dsit_pkg::TABLE_DEPTH);
        if (w.opcode == dsit_pkg::OP_INSERT) begin
            if (row_count < limit) begin
                new_key = {w.key_year, w.key_month, w.key_day};
                slot = '0;
                while (slot < row_count && {table_rows[slot[3:0]].year,
                        table_rows[slot[3:0]].month, table_rows[slot[3:0]].day} >= new_key) begin
                    slot++;
                end
                for (k = row_count; k > slot; k--) begin
                    table_rows[k[3:0]] = table_rows[4'(k - 5'd1)];
                end
                table_rows[slot[3:0]] = {w.key_year, w.key_month, w.key_day,
                                         w.record_payload[dsit_pkg::PAYLOAD_WIDTH-1:0]};
                row_count++;
                r.accepted        = 1'b1;
                r.insert_position = slot[3:0];
            end
        end else if ({1'b0, w.read_index} < row_count) begin
            r.accepted    = 1'b1;
            r.out_year    = table_rows[w.read_index].year;
            r.out_month   = table_rows[w.read_index].month;
            r.out_day     = table_rows[w.read_index].day;
            r.out_payload = 32'(table_rows[w.read_index].payload);
        end
        r.entry_count = row_count;
    endtask

    always @(posedge i_clk) begin
        dsit_pkg::t_out_word want;
        if (!i_rst_n) begin
            row_count = '0;
            capacity  = 5'd16;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result word arrived with nothing pending");
                end else begin
                    want = due_results.pop_front();
                    check_field("accepted", 32'(i_out_word.accepted), 32'(want.accepted));
                    check_field("insert_position", 32'(i_out_word.insert_position),
                                32'(want.insert_position));
                    check_field("entry_count", 32'(i_out_word.entry_count),
                                32'(want.entry_count));
                    check_field("out_year", 32'(i_out_word.out_year), 32'(want.out_year));
                    check_field("out_month", 32'(i_out_word.out_month), 32'(want.out_month));
                    check_field("out_day", 32'(i_out_word.out_day), 32'(want.out_day));
                    check_field("out_payload", i_out_word.out_payload, want.out_payload);
                end
            end
            if (i_in_valid && i_in_ready) begin
                place_or_fetch(i_in_word, want);
                due_results.push_back(want);
            end
        end
        due_total = due_results.size();
    end

endmodule

// ===== verif/tb_date_sorted_insert_table_core.sv =====
module tb_date_sorted_insert_table_core;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [4:0]          cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    dsit_pkg::t_in_word  in_word = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    dsit_pkg::t_out_word out_word;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_requests = 0;
    int holds_done = 0;
    int mismatches;
    int due;

    date_sorted_insert_table_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    date_table_checker results_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_mismatches (mismatches),
        .o_due        (due)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // The long hold lets the output register and the input side back up.
    initial begin
        forever begin
            @(negedge clk);
            if (holds_done < hold_requests) begin
                out_ready <= 1'b0;
                repeat (199) @(negedge clk);
                holds_done++;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic dsit_pkg::t_in_word random_word(input logic op);
        dsit_pkg::t_in_word w;
        w.opcode         = op;
        w.key_year       = 12'($urandom);
        w.key_month      = 4'($urandom);
        w.key_day        = 5'($urandom);
        w.record_payload = $urandom;
        w.read_index     = 4'($urandom);
        return w;
    endfunction

    function automatic dsit_pkg::t_in_word insert_word(input logic [11:0] y,
                                                       input logic [3:0] m,
                                                       input logic [4:0] d,
                                                       input logic [31:0] p);
        dsit_pkg::t_in_word w;
        w = random_word(dsit_pkg::OP_INSERT);
        w.key_year       = y;
        w.key_month      = m;
        w.key_day        = d;
        w.record_payload = p;
        return w;
    endfunction

    function automatic dsit_pkg::t_in_word read_word(input logic [3:0] idx);
        dsit_pkg::t_in_word w;
        w = random_word(dsit_pkg::OP_READ);
        w.read_index = idx;
        return w;
    endfunction

    // Dates cluster on a few years so that equal keys and near ties are common.
    function automatic dsit_pkg::t_in_word random_insert();
        dsit_pkg::t_in_word w;
        w = random_word(dsit_pkg::OP_INSERT);
        if ($urandom_range(0, 1) == 0) begin
            w.key_year = 12'(2018 + $urandom_range(0, 2));
        end
        if ($urandom_range(0, 3) != 0) begin
            w.key_month = 4'($urandom_range(1, 12));
        end
        if ($urandom_range(0, 3) != 0) begin
            w.key_day = 5'($urandom_range(1, 3));
        end
        return w;
    endfunction

    task automatic send_word(input dsit_pkg::t_in_word w);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [4:0] cap);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [4:0] cap;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // With no room every insert is refused and reads find nothing.
        set_capacity(5'd0);
        send_word(insert_word(12'hfff, 4'hf, 5'h1f, 32'hffff_ffff));
        send_word(read_word(4'd0));
        send_word(read_word(4'd15));

        set_capacity(5'd1);
        send_word(insert_word(12'd2020, 4'd6, 5'd15, 32'h1234_5678));
        send_word(insert_word(12'hfff, 4'hf, 5'h1f, 32'hffff_ffff));
        send_word(read_word(4'd0));
        send_word(read_word(4'd1));

        set_capacity(5'd6);
        send_word(insert_word(12'hfff, 4'hf, 5'h1f, 32'hffff_ffff));
        send_word(insert_word(12'd0, 4'd0, 5'd0, 32'h0));
        send_word(insert_word(12'd2020, 4'd6, 5'd15, 32'hcafe_0001));
        send_word(insert_word(12'd2020, 4'd7, 5'd1, 32'h5555_aaaa));
        send_word(insert_word(12'd2020, 4'd6, 5'd16, 32'haaaa_5555));
        for (int i = 0; i < 7; i++) begin
            send_word(read_word(4'(i)));
        end

        for (int phase = 0; phase < 11; phase++) begin
            case (phase)
                0:       cap = 5'd8;
                1:       cap = 5'd5;
                2:       cap = 5'd12;
                3:       cap = 5'd0;
                4:       cap = 5'd16;
                5:       cap = 5'd31;
                6:       cap = 5'd17;
                7:       cap = 5'd1;
                10:      cap = 5'd16;
                default: cap = 5'($urandom_range(0, 31));
            endcase
            set_capacity(cap);
            if (phase == 2 || phase == 6) begin
                hold_requests++;
            end
            if (phase == 10) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 9) < 4) begin
                    send_word(random_insert());
                end else begin
                    send_word(random_word(dsit_pkg::OP_READ));
                end
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dsit_pkg.sv
rtl/core/dsit_cell.sv
rtl/core/date_sorted_insert_table_core.sv
verif/date_table_checker.sv
verif/tb_date_sorted_insert_table_core.sv
